FILE: hw/rtl/rprc_pkg.sv
// ----------------------------------------------------------------------------
// Reflow profile ramp controller package
// Widths, codes, state encodings and profile lookup helpers shared by the
// controller.
// ----------------------------------------------------------------------------
package rprc_pkg;

  // Profile geometry
  localparam int MAX_PHASES = 10;
  localparam int NUM_WORDS  = 5;
  localparam int WORD_W     = 64;
  localparam int HALF_W     = 32;
  localparam int PHASE_W    = 4;
  localparam int DUR_W      = 16;
  localparam int TGT_W      = 16;
  localparam int START_W    = 10;
  localparam int START_RST  = 25;
  localparam int CFG_IDX_W  = 3;

  // Stream payload widths
  localparam int SAMPLE_W   = 12;
  localparam int SP_W       = 12;
  localparam int CMD_W      = 2;
  localparam int MODE_W     = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  // Arithmetic widths
  localparam int MUL_OP_W   = 17;
  localparam int PROD_W     = 34;
  localparam int ACC_W      = 35;
  localparam int NUM_W      = 37;
  localparam int REM_W      = 28;
  localparam int DIV_IDX_W  = 4;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] profile_t;

  // Run mode, reported as run_status
  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ARMED = 2'd1,
    MODE_RUN   = 2'd2
  } mode_t;

  // Input beat kinds
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_PRESS   = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORD0 = 3'd0,
    CFG_WORD1 = 3'd1,
    CFG_WORD2 = 3'd2,
    CFG_WORD3 = 3'd3,
    CFG_WORD4 = 3'd4,
    CFG_COUNT = 3'd5,
    CFG_START = 3'd6
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_SCAN  = 10'b0000000010,
    ST_EVAL  = 10'b0000000100,
    ST_MUL_A = 10'b0000001000,
    ST_MUL_B = 10'b0000010000,
    ST_MUL_C = 10'b0000100000,
    ST_CHECK = 10'b0001000000,
    ST_DIV   = 10'b0010000000,
    ST_POST  = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_t;

  // One phase entry; phases beyond the table read as zero.
  function automatic logic [HALF_W-1:0] phase_half(input profile_t words,
                                                   input logic [PHASE_W-1:0] p);
    logic [HALF_W-1:0] half;
    half = '0;
    if (p < PHASE_W'(MAX_PHASES)) begin
      half = p[0] ? words[p[PHASE_W-1:1]][WORD_W-1:HALF_W]
                  : words[p[PHASE_W-1:1]][HALF_W-1:0];
    end
    return half;
  endfunction

  function automatic logic [DUR_W-1:0] phase_dur(input profile_t words,
                                                 input logic [PHASE_W-1:0] p);
    logic [HALF_W-1:0] half;
    half = phase_half(words, p);
    return half[DUR_W-1:0];
  endfunction

  function automatic logic [TGT_W-1:0] phase_tgt(input profile_t words,
                                                 input logic [PHASE_W-1:0] p);
    logic [HALF_W-1:0] half;
    half = phase_half(words, p);
    return half[HALF_W-1:DUR_W];
  endfunction

endpackage

FILE: hw/rtl/reflow_profile_ramp_controller_unit.sv
// ----------------------------------------------------------------------------
// Reflow profile ramp controller
// Runs a profile of up to ten ramp phases and drives a heater relay by
// comparing each thermocouple sample against the linear ramp setpoint.
// ----------------------------------------------------------------------------
// One input beat yields one result beat; a finished beat waits in the
// sequencer until the output register is free or being read. A tick while
// running walks one shared 17 x 17 signed multiplier three times (start offset
// times duration, rise times elapsed seconds, sample times duration), makes
// one compare and then, unless the setpoint is zero or saturated, runs a
// twelve step restoring division of the ramp numerator by the duration; a run
// start or a phase change scans the profile one phase per cycle for the next
// phase of nonzero duration. The input side is ready only while the sequencer
// is idle; a finished result waits in the output register, so the next beat
// can be taken while the previous result is still pending.
module reflow_profile_ramp_controller_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_tdata: sample_quarter_deg [11:0], zero fill above
  input  logic [rprc_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: command [1:0]
  input  logic [rprc_pkg::CMD_W-1:0]      in_tuser,
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata: relay_on [0], setpoint_quarter_deg [12:1], phase_index [16:13],
  //   elapsed_seconds [32:17], run_status [34:33], run_aborted [35], zero fill
  output logic [rprc_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tlast: run_finished
  output logic                            out_tlast,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [rprc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [rprc_pkg::WORD_W-1:0]     cfg_wdata
);
  import rprc_pkg::*;

  // Configuration registers
  profile_t               profile_r;
  logic [PHASE_W-1:0]     phase_count_r;
  logic [START_W-1:0]     start_temp_r;

  // Run state
  state_t                 state_r, state_nxt;
  mode_t                  mode_r;
  logic [PHASE_W-1:0]     cur_phase_r;
  logic [DUR_W-1:0]       sec_r;
  logic                   relay_r;

  // Work registers for the current beat
  logic                   tick_r;
  logic [SAMPLE_W-1:0]    sample_r;
  logic [PHASE_W-1:0]     wp_r;
  logic [DUR_W-1:0]       we_r;
  logic [PHASE_W-1:0]     scan_p_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [REM_W-1:0]       rem_r;
  logic [DIV_IDX_W-1:0]   div_i_r;
  logic [SP_W-1:0]        sp_r;
  logic                   fin_r;
  logic                   abt_r;

  // Output register
  logic                   out_valid_r;
  logic                   out_relay_r;
  logic [SP_W-1:0]        out_sp_r;
  logic [PHASE_W-1:0]     out_phase_r;
  logic [DUR_W-1:0]       out_elapsed_r;
  mode_t                  out_status_r;
  logic                   out_fin_r;
  logic                   out_abt_r;

  // Combinational helpers
  logic                     accept;
  logic                     out_load;
  logic [DUR_W-1:0]         dur_w;
  logic [TGT_W-1:0]         tgt_w;
  logic [TGT_W-1:0]         off_w;
  logic [PHASE_W-1:0]       lim_w;
  logic [DUR_W-1:0]         scan_dur_w;
  logic                     scan_in_range;
  logic signed [MUL_OP_W-1:0] mul_a;
  logic signed [MUL_OP_W-1:0] mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [NUM_W-1:0]    num_w;
  logic signed [NUM_W-1:0]    sd_w;
  logic signed [NUM_W-1:0]    dsat_w;
  logic                     sp_zero;
  logic                     sp_sat;
  logic [REM_W-1:0]         dsh_w;
  logic                     rem_ge;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Phase operands of the phase being worked on
  assign dur_w = phase_dur(profile_r, wp_r);
  assign tgt_w = phase_tgt(profile_r, wp_r);
  assign off_w = (wp_r == '0) ? {{(TGT_W-START_W){1'b0}}, start_temp_r}
                              : phase_tgt(profile_r, wp_r - PHASE_W'(1));

  // Phase limit and scan lookup
  assign lim_w = (phase_count_r > PHASE_W'(MAX_PHASES)) ? PHASE_W'(MAX_PHASES)
                                                         : phase_count_r;
  assign scan_dur_w    = phase_dur(profile_r, scan_p_r);
  assign scan_in_range = (scan_p_r < lim_w);

  // Shared multiplier operand selection
  always_comb begin
    unique case (state_r)
      ST_MUL_A: begin
        mul_a = $signed({1'b0, off_w});
        mul_b = $signed({1'b0, dur_w});
      end
      ST_MUL_B: begin
        mul_a = $signed({1'b0, tgt_w}) - $signed({1'b0, off_w});
        mul_b = $signed({1'b0, we_r});
      end
      default: begin
        mul_a = $signed({{(MUL_OP_W-SAMPLE_W){1'b0}}, sample_r});
        mul_b = $signed({1'b0, dur_w});
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Ramp numerator 4 * (off * d + (tgt - off) * e) and its comparisons
  assign num_w   = $signed({acc_r, 2'b00});
  assign sd_w    = NUM_W'(prod_r);
  assign dsat_w  = $signed({{(NUM_W-DUR_W-SP_W){1'b0}}, dur_w, {SP_W{1'b0}}});
  assign sp_zero = (dur_w == '0) || num_w[NUM_W-1];
  assign sp_sat  = (num_w >= dsat_w);

  // One restoring division step
  assign dsh_w  = {{(REM_W-DUR_W){1'b0}}, dur_w} << div_i_r;
  assign rem_ge = (rem_r >= dsh_w);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == CMD_RELEASE && mode_r == MODE_ARMED) begin
            state_nxt = ST_SCAN;
          end else if (in_tuser == CMD_TICK && mode_r == MODE_RUN) begin
            state_nxt = ST_MUL_A;
          end else begin
            state_nxt = ST_EVAL;
          end
        end
      end
      ST_SCAN: begin
        if (!(scan_in_range && scan_dur_w == '0)) begin
          state_nxt = tick_r ? ST_DONE : ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = (mode_r == MODE_RUN) ? ST_MUL_A : ST_DONE;
      end
      ST_MUL_A: state_nxt = ST_MUL_B;
      ST_MUL_B: state_nxt = ST_MUL_C;
      ST_MUL_C: state_nxt = ST_CHECK;
      ST_CHECK: begin
        state_nxt = (sp_zero || sp_sat) ? ST_POST : ST_DIV;
      end
      ST_DIV: begin
        if (div_i_r == '0) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        state_nxt = (tick_r && we_r >= dur_w) ? ST_SCAN : ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, configuration and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      mode_r        <= MODE_IDLE;
      cur_phase_r   <= '0;
      sec_r         <= '0;
      relay_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      profile_r     <= '0;
      phase_count_r <= '0;
      start_temp_r  <= START_W'(START_RST);
    end else begin
      state_r <= state_nxt;

      // Configuration writes
      if (cfg_we) begin
        unique case (cfg_addr) inside
          CFG_WORD0, CFG_WORD1, CFG_WORD2, CFG_WORD3, CFG_WORD4: begin
            profile_r[cfg_addr] <= cfg_wdata;
          end
          CFG_COUNT: phase_count_r <= cfg_wdata[PHASE_W-1:0];
          CFG_START: start_temp_r  <= cfg_wdata[START_W-1:0];
          default: ;
        endcase
      end

      // Button commands and the elapsed second on a tick
      if (accept) begin
        unique case (in_tuser)
          CMD_PRESS: begin
            if (mode_r == MODE_IDLE) begin
              mode_r <= MODE_ARMED;
            end else if (mode_r == MODE_RUN) begin
              mode_r      <= MODE_IDLE;
              relay_r     <= 1'b0;
              cur_phase_r <= '0;
              sec_r       <= '0;
            end
          end
          CMD_TICK: begin
            if (mode_r == MODE_RUN) begin
              sec_r <= sec_r + DUR_W'(1);
            end
          end
          default: ;
        endcase
      end

      // Next phase of nonzero duration, or the end of the run
      if (state_r == ST_SCAN) begin
        if (!scan_in_range) begin
          mode_r      <= MODE_IDLE;
          relay_r     <= 1'b0;
          cur_phase_r <= '0;
          sec_r       <= '0;
        end else if (scan_dur_w != '0) begin
          mode_r      <= MODE_RUN;
          cur_phase_r <= scan_p_r;
          sec_r       <= '0;
        end
      end

      // Relay follows the exact cross-multiplied comparison on a tick
      if (state_r == ST_CHECK && tick_r) begin
        relay_r <= (sd_w < num_w);
      end

      // Output register valid
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Work datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          tick_r   <= (in_tuser == CMD_TICK) && (mode_r == MODE_RUN);
          sample_r <= in_tdata[SAMPLE_W-1:0];
          sp_r     <= '0;
          fin_r    <= 1'b0;
          abt_r    <= (in_tuser == CMD_PRESS) && (mode_r == MODE_RUN);
          scan_p_r <= '0;
          wp_r     <= cur_phase_r;
          we_r     <= sec_r + DUR_W'(1);
        end
      end
      ST_SCAN: begin
        if (!scan_in_range) begin
          fin_r <= 1'b1;
        end else if (scan_dur_w == '0) begin
          scan_p_r <= scan_p_r + PHASE_W'(1);
        end
      end
      ST_EVAL: begin
        wp_r <= cur_phase_r;
        we_r <= sec_r;
      end
      ST_MUL_A: begin
        prod_r <= mul_p;
      end
      ST_MUL_B: begin
        prod_r <= mul_p;
        acc_r  <= ACC_W'(prod_r);
      end
      ST_MUL_C: begin
        prod_r <= mul_p;
        acc_r  <= acc_r + ACC_W'(prod_r);
      end
      ST_CHECK: begin
        if (!sp_zero && sp_sat) begin
          sp_r <= {SP_W{1'b1}};
        end
        rem_r   <= num_w[REM_W-1:0];
        div_i_r <= DIV_IDX_W'(SP_W - 1);
      end
      ST_DIV: begin
        if (rem_ge) begin
          rem_r            <= rem_r - dsh_w;
          sp_r[div_i_r]    <= 1'b1;
        end
        div_i_r <= div_i_r - DIV_IDX_W'(1);
      end
      ST_POST: begin
        scan_p_r <= wp_r + PHASE_W'(1);
      end
      ST_DONE: begin
        if (out_load) begin
          out_relay_r   <= relay_r;
          out_sp_r      <= sp_r;
          out_phase_r   <= wp_r;
          out_elapsed_r <= we_r;
          out_status_r  <= mode_r;
          out_fin_r     <= fin_r;
          out_abt_r     <= abt_r;
        end
      end
      default: ;
    endcase
  end

  // Result beat
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_fin_r;
  assign out_tdata  = {{(OUT_DATA_W-36){1'b0}}, out_abt_r, out_status_r,
                       out_elapsed_r, out_phase_r, out_sp_r, out_relay_r};

endmodule
